>>> sv/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants and the default command type for the prefix set subtract
// block.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int ADDR_BITS_DEF   = 32;
    localparam int LEN_W_DEF       = $clog2(ADDR_BITS_DEF + 1);
    localparam int QUEUE_DEPTH_DEF = 2;

    // One classified pair as the back end replays it.  Every piece is
    // (addr & mask) ^ flip, with lengths running from len_lo to len_hi.
    typedef struct packed {
        logic [ADDR_BITS_DEF-1:0] addr;
        logic [ADDR_BITS_DEF-1:0] mask;
        logic [ADDR_BITS_DEF-1:0] flip;
        logic [LEN_W_DEF-1:0]     len_lo;
        logic [LEN_W_DEF-1:0]     len_hi;
        logic                     present;
    } sps_cmd_def_t;

endpackage

>>> sv/sps_ifs.sv
// ----------------------------------------------------------------------------
// sps_ifs
// Valid/ready channels of the prefix set subtract block: the input pair of
// prefixes and the output pieces.
// ----------------------------------------------------------------------------
interface sps_pair_if
    import sps_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
);
    localparam int LEN_W = $clog2(ADDR_BITS + 1);

    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] left_addr;
    logic [LEN_W-1:0]     left_len;
    logic [ADDR_BITS-1:0] right_addr;
    logic [LEN_W-1:0]     right_len;

    modport source (output valid, output left_addr, output left_len,
                    output right_addr, output right_len, input ready);
    modport sink   (input valid, input left_addr, input left_len,
                    input right_addr, input right_len, output ready);
endinterface

interface sps_piece_if
    import sps_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
);
    localparam int LEN_W = $clog2(ADDR_BITS + 1);

    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] piece_addr;
    logic [LEN_W-1:0]     piece_len;
    logic                 present;
    logic                 last;

    modport source (output valid, output piece_addr, output piece_len,
                    output present, output last, input ready);
    modport sink   (input valid, input piece_addr, input piece_len,
                    input present, input last, output ready);
endinterface

>>> sv/sps_front.sv
// ----------------------------------------------------------------------------
// sps_front
// Accepts a pair of prefixes, normalizes the lengths and addresses, and
// classifies the pair into one command for the back end.
// ----------------------------------------------------------------------------
module sps_front
    import sps_pkg::*;
#(
    parameter int  ADDR_BITS = ADDR_BITS_DEF,
    parameter type cmd_t     = sps_cmd_def_t
)
(
    sps_pair_if.sink   pair,
    output logic       push_valid,
    input  logic       push_ready,
    output cmd_t       push_cmd
);

    localparam int                   LEN_W   = $clog2(ADDR_BITS + 1);
    localparam logic [ADDR_BITS-1:0] ONES    = {ADDR_BITS{1'b1}};
    localparam logic [ADDR_BITS-1:0] TOP_BIT = {1'b1, {(ADDR_BITS-1){1'b0}}};
    localparam logic [LEN_W-1:0]     MAX_LEN = LEN_W'(ADDR_BITS);

    logic [LEN_W-1:0]     llen;
    logic [LEN_W-1:0]     rlen;
    logic [ADDR_BITS-1:0] lmask;
    logic [ADDR_BITS-1:0] rmask;
    logic [ADDR_BITS-1:0] laddr;
    logic [ADDR_BITS-1:0] raddr;
    logic [ADDR_BITS-1:0] split_flip;
    logic                 shorter;
    logic                 split;
    logic                 empty;

    assign pair.ready = push_ready;
    assign push_valid = pair.valid;

    always_comb
    begin
        llen       = (pair.left_len > MAX_LEN) ? MAX_LEN : pair.left_len;
        rlen       = (pair.right_len > MAX_LEN) ? MAX_LEN : pair.right_len;
        lmask      = ~(ONES >> llen);
        rmask      = ~(ONES >> rlen);
        laddr      = pair.left_addr & lmask;
        raddr      = pair.right_addr & rmask;
        split_flip = TOP_BIT >> llen;
        shorter    = llen < rlen;
        split      = shorter && ((raddr & lmask) == laddr);
        empty      = !shorter && ((laddr & rmask) == raddr);

        priority if (split)
        begin
            // Right lies strictly inside left: emit the siblings of right's
            // ancestors from length llen+1 up to rlen.
            push_cmd.addr    = raddr;
            push_cmd.flip    = split_flip;
            push_cmd.mask    = lmask | split_flip;
            push_cmd.len_lo  = llen + LEN_W'(1);
            push_cmd.len_hi  = rlen;
            push_cmd.present = 1'b1;
        end
        else if (empty)
        begin
            push_cmd.addr    = '0;
            push_cmd.flip    = '0;
            push_cmd.mask    = ONES;
            push_cmd.len_lo  = '0;
            push_cmd.len_hi  = '0;
            push_cmd.present = 1'b0;
        end
        else
        begin
            push_cmd.addr    = laddr;
            push_cmd.flip    = '0;
            push_cmd.mask    = ONES;
            push_cmd.len_lo  = llen;
            push_cmd.len_hi  = llen;
            push_cmd.present = 1'b1;
        end
    end

endmodule

>>> sv/sps_queue.sv
// ----------------------------------------------------------------------------
// sps_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sps_queue
    import sps_pkg::*;
#(
    parameter int  DEPTH = QUEUE_DEPTH_DEF,
    parameter type cmd_t = sps_cmd_def_t
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> sv/sps_back.sv
// ----------------------------------------------------------------------------
// sps_back
// Replays one command as a run of pieces, one per cycle while the output is not
// stalled, into an output register.
// ----------------------------------------------------------------------------
module sps_back
    import sps_pkg::*;
#(
    parameter int  ADDR_BITS = ADDR_BITS_DEF,
    parameter type cmd_t     = sps_cmd_def_t
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  cmd_t        pop_cmd,
    sps_piece_if.source piece
);

    localparam int LEN_W = $clog2(ADDR_BITS + 1);

    logic                 busy_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] mask_reg;
    logic [ADDR_BITS-1:0] flip_reg;
    logic [LEN_W-1:0]     cur_reg;
    logic [LEN_W-1:0]     end_reg;
    logic                 present_reg;
    logic                 out_valid_reg;
    logic [ADDR_BITS-1:0] piece_addr_reg;
    logic [LEN_W-1:0]     piece_len_reg;
    logic                 present_out_reg;
    logic                 last_reg;
    logic                 emit;
    logic                 at_end;

    assign pop_ready = !busy_reg;
    assign emit      = busy_reg && (!out_valid_reg || piece.ready);
    assign at_end    = cur_reg == end_reg;

    assign piece.valid      = out_valid_reg;
    assign piece.piece_addr = piece_addr_reg;
    assign piece.piece_len  = piece_len_reg;
    assign piece.present    = present_out_reg;
    assign piece.last       = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (piece.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop_valid && !busy_reg)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit && at_end)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_valid && !busy_reg)
        begin
            addr_reg    <= pop_cmd.addr;
            mask_reg    <= pop_cmd.mask;
            flip_reg    <= pop_cmd.flip;
            cur_reg     <= pop_cmd.len_lo;
            end_reg     <= pop_cmd.len_hi;
            present_reg <= pop_cmd.present;
        end
        else if (emit)
        begin
            cur_reg  <= cur_reg + LEN_W'(1);
            flip_reg <= flip_reg >> 1;
            mask_reg <= mask_reg | (flip_reg >> 1);
        end
        if (emit)
        begin
            piece_addr_reg  <= (addr_reg & mask_reg) ^ flip_reg;
            piece_len_reg   <= cur_reg;
            present_out_reg <= present_reg;
            last_reg        <= at_end;
        end
    end

endmodule

>>> sv/prefix_set_subtract.sv
// The first piece of a pair is registered in a queue entry, the generator's command
// registers and the output register. A pair yields at most ADDR_BITS pieces and
// holds the generator until its last one; pieces leave one per cycle unless stalled.
// A queue of QUEUE_DEPTH commands lets new pairs be taken while a run is emitted.
// Reset clears the queue and all valid flags; no transaction is pending after reset.
// ----------------------------------------------------------------------------
// prefix_set_subtract
// Subtracts one address prefix from another and emits the difference as a
// run of disjoint prefixes.
// ----------------------------------------------------------------------------
module prefix_set_subtract
    import sps_pkg::*;
#(
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    sps_pair_if.sink    pair,
    sps_piece_if.source piece
);

    localparam int LEN_W = $clog2(ADDR_BITS + 1);

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] mask;
        logic [ADDR_BITS-1:0] flip;
        logic [LEN_W-1:0]     len_lo;
        logic [LEN_W-1:0]     len_hi;
        logic                 present;
    } cmd_t;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    sps_front #(
        .ADDR_BITS (ADDR_BITS),
        .cmd_t     (cmd_t)
    ) u_front (
        .pair       (pair),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    sps_queue #(
        .DEPTH (QUEUE_DEPTH),
        .cmd_t (cmd_t)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    sps_back #(
        .ADDR_BITS (ADDR_BITS),
        .cmd_t     (cmd_t)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .piece     (piece)
    );

endmodule

>>> sv/sps_checker.sv
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks on the output pieces of the prefix set subtract block.
// ----------------------------------------------------------------------------
module sps_checker
    import sps_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               piece_valid,
    input logic                               piece_ready,
    input logic [ADDR_BITS-1:0]               piece_addr,
    input logic [$clog2(ADDR_BITS + 1)-1:0]   piece_len,
    input logic                               present,
    input logic                               last
);

    localparam int                   LEN_W = $clog2(ADDR_BITS + 1);
    localparam logic [ADDR_BITS-1:0] ONES  = {ADDR_BITS{1'b1}};

    logic                 out_xfer;
    logic [ADDR_BITS-1:0] host_mask;
    logic                 in_run_reg;
    logic [LEN_W-1:0]     prev_len_reg;

    assign out_xfer  = piece_valid && piece_ready;
    assign host_mask = ONES >> piece_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg   <= 1'b0;
            prev_len_reg <= '0;
        end
        else if (out_xfer)
        begin
            in_run_reg   <= !last;
            prev_len_reg <= piece_len;
        end
    end

    // A stalled transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && !piece_ready |=>
            piece_valid && $stable(piece_addr) && $stable(piece_len)
            && $stable(present) && $stable(last))
        else $error("piece payload changed while stalled");

    // An empty difference is a single, all-zero closing piece.
    assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && !present |-> last && piece_addr == '0 && piece_len == '0)
        else $error("empty result is malformed");

    // A present piece is a proper prefix with its host bits clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && present |->
            piece_len <= LEN_W'(ADDR_BITS) && (piece_addr & host_mask) == '0)
        else $error("piece has host bits set or a length out of range");

    // Within a run, each piece is one bit longer than the one before.
    assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && in_run_reg |->
            present && piece_len == prev_len_reg + LEN_W'(1))
        else $error("run of pieces is not in increasing length order");

endmodule

bind prefix_set_subtract sps_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_sps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .piece_valid (piece.valid),
    .piece_ready (piece.ready),
    .piece_addr  (piece.piece_addr),
    .piece_len   (piece.piece_len),
    .present     (piece.present),
    .last        (piece.last)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for prefix_set_subtract. A table of directed prefix pairs and a
// stream of random pairs, mostly nested, are sent through the pair channel.
// Each piece that leaves the block is compared field by field with the
// oldest expected piece, which comes from the table or from a predictor that
// is built into this testbench. Both channels idle at random, and the
// receiver holds off once for a long stretch so that the block stalls.
// ----------------------------------------------------------------------------
module tb;
    import sps_pkg::*;

    localparam int AW        = ADDR_BITS_DEF;
    localparam int LW        = LEN_W_DEF;
    localparam int N_RANDOM  = 320;
    localparam int N_ROWS    = 17;
    localparam int HOLD_LEN  = 250;
    localparam int DRAIN_LEN = 40;

    typedef struct packed {
        logic [AW-1:0] addr;
        logic [LW-1:0] len;
        logic          present;
        logic          last;
    } piece_t;

    typedef struct {
        logic [AW-1:0] left_addr;
        logic [LW-1:0] left_len;
        logic [AW-1:0] right_addr;
        logic [LW-1:0] right_len;
        bit            typed;
        logic [AW-1:0] exp_addr;
        logic [LW-1:0] exp_len;
        logic          exp_present;
    } pair_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic steady;
    logic stall_hold;
    bit   pressure_go;

    piece_t    pending_pieces[$];
    piece_t    want;
    pair_row_t directed_rows[N_ROWS];
    int        pairs_sent;
    int        pieces_seen;
    int        empty_seen;
    int        run_len;
    int        longest_run;
    int        mismatches;

    sps_pair_if  #(.ADDR_BITS(AW)) pair_ch ();
    sps_piece_if #(.ADDR_BITS(AW)) piece_ch ();

    prefix_set_subtract #(.ADDR_BITS(AW)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pair  (pair_ch),
        .piece (piece_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [AW-1:0] prefix_mask(input int unsigned n);
        if (n == 0)
            return '0;
        return {AW{1'b1}} << (AW - n);
    endfunction

    function automatic void expect_piece(input logic [AW-1:0] addr, input int unsigned len,
                                         input logic present, input logic last);
        piece_t p;
        p.addr    = addr;
        p.len     = LW'(len);
        p.present = present;
        p.last    = last;
        pending_pieces = {pending_pieces, p};
    endfunction

    function automatic void subtract_prefixes(input logic [AW-1:0] left_addr,
                                              input logic [LW-1:0] left_len,
                                              input logic [AW-1:0] right_addr,
                                              input logic [LW-1:0] right_len);
        int unsigned   llen;
        int unsigned   rlen;
        logic [AW-1:0] la;
        logic [AW-1:0] ra;
        logic [AW-1:0] sib;
        llen = (left_len > AW) ? AW : left_len;
        rlen = (right_len > AW) ? AW : right_len;
        la   = left_addr & prefix_mask(llen);
        ra   = right_addr & prefix_mask(rlen);
        if (llen < rlen)
        begin
            if ((ra & prefix_mask(llen)) == la)
            begin
                for (int unsigned l = llen + 1; l <= rlen; l++)
                begin
                    sib = (ra & prefix_mask(l)) ^ (AW'(1) << (AW - l));
                    expect_piece(sib, l, 1'b1, l == rlen);
                end
            end
            else
                expect_piece(la, llen, 1'b1, 1'b1);
        end
        else if ((la & prefix_mask(rlen)) == ra)
            expect_piece('0, 0, 1'b0, 1'b1);
        else
            expect_piece(la, llen, 1'b1, 1'b1);
    endfunction

    function automatic pair_row_t random_pair();
        pair_row_t   r;
        int unsigned mode;
        int unsigned ll;
        int unsigned rl;
        int unsigned m;
        mode    = $urandom_range(0, 9);
        r.typed = 1'b0;
        r.exp_addr = '0;
        r.exp_len  = '0;
        r.exp_present = 1'b0;
        if (mode <= 5)
        begin
            ll = $urandom_range(0, 31);
            rl = $urandom_range(ll + 1, 32);
            r.left_addr  = $urandom;
            r.right_addr = (r.left_addr & prefix_mask(ll)) | ($urandom & ~prefix_mask(ll));
            if (rl == 32 && $urandom_range(0, 7) == 0)
                rl = $urandom_range(33, 63);
        end
        else if (mode == 6)
        begin
            rl = $urandom_range(0, 32);
            ll = $urandom_range(rl, 32);
            r.right_addr = $urandom;
            r.left_addr  = (r.right_addr & prefix_mask(rl)) | ($urandom & ~prefix_mask(rl));
        end
        else if (mode == 7)
        begin
            ll = $urandom_range(1, 32);
            rl = $urandom_range(1, 32);
            m  = (ll < rl) ? ll : rl;
            r.left_addr  = $urandom;
            r.right_addr = $urandom ^ (AW'(1) << (AW - $urandom_range(1, m)));
            r.right_addr = (r.right_addr & ~prefix_mask(m))
                         | ((r.left_addr & prefix_mask(m))
                            ^ (AW'(1) << (AW - $urandom_range(1, m))));
        end
        else
        begin
            ll = $urandom_range(0, 63);
            rl = $urandom_range(0, 63);
            r.left_addr  = $urandom;
            r.right_addr = $urandom;
        end
        r.left_len  = LW'(ll);
        r.right_len = LW'(rl);
        return r;
    endfunction

    task automatic send_pair(input pair_row_t r);
        while (!steady && $urandom_range(0, 99) < 7)
        begin
            pair_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pair_ch.valid      <= 1'b1;
        pair_ch.left_addr  <= r.left_addr;
        pair_ch.left_len   <= r.left_len;
        pair_ch.right_addr <= r.right_addr;
        pair_ch.right_len  <= r.right_len;
        @(posedge clk);
        while (!pair_ch.ready)
            @(posedge clk);
        if (r.typed)
            expect_piece(r.exp_addr, int'(r.exp_len), r.exp_present, 1'b1);
        else
            subtract_prefixes(r.left_addr, r.left_len, r.right_addr, r.right_len);
        pairs_sent++;
    endtask

    initial
    begin
        directed_rows = '{
            '{32'h0000_0000,  0, 32'h0000_0000,  0, 1, 32'h0000_0000,  0, 0},
            '{32'hFFFF_FFFF, 32, 32'h0000_0000,  0, 1, 32'h0000_0000,  0, 0},
            '{32'hFFFF_FFFF, 32, 32'hFFFF_FFFF, 32, 1, 32'h0000_0000,  0, 0},
            '{32'h0000_0000,  0, 32'h8000_0000,  1, 1, 32'h0000_0000,  1, 1},
            '{32'h0000_0000,  0, 32'hFFFF_FFFF, 32, 0, 32'h0000_0000,  0, 0},
            '{32'h0A00_0000,  8, 32'h0B00_0000,  8, 1, 32'h0A00_0000,  8, 1},
            '{32'h0AFF_FFFF,  8, 32'h0BFF_FFFF, 16, 1, 32'h0A00_0000,  8, 1},
            '{32'hC0A8_0000, 16, 32'hC0A8_FF01, 24, 0, 32'h0000_0000,  0, 0},
            '{32'h0A00_0001, 63, 32'h0A00_0001, 63, 1, 32'h0000_0000,  0, 0},
            '{32'h0A00_0001, 40, 32'h0A00_0002, 33, 1, 32'h0A00_0001, 32, 1},
            '{32'h1234_5678,  0, 32'h1234_5678, 63, 0, 32'h0000_0000,  0, 0},
            '{32'h0A0A_0000, 16, 32'h0A00_0000,  8, 1, 32'h0000_0000,  0, 0},
            '{32'h0A0A_0000, 16, 32'h0B00_0000,  8, 1, 32'h0A0A_0000, 16, 1},
            '{32'h7FFF_FFFF,  1, 32'h7FFF_FFFF,  2, 0, 32'h0000_0000,  0, 0},
            '{32'h8000_0000, 31, 32'h8000_0001, 32, 1, 32'h8000_0000, 32, 1},
            '{32'hFFFF_FFFF, 63, 32'h0000_0000,  0, 1, 32'h0000_0000,  0, 0},
            '{32'h0000_0000, 32, 32'h0000_0001, 32, 1, 32'h0000_0000, 32, 1}
        };
        rst_n              = 1'b0;
        steady             = 1'b0;
        pressure_go        = 1'b0;
        pair_ch.valid      = 1'b0;
        pair_ch.left_addr  = '0;
        pair_ch.left_len   = '0;
        pair_ch.right_addr = '0;
        pair_ch.right_len  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            send_pair(directed_rows[i]);

        pressure_go = 1'b1;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            steady <= (i >= 120 && i < 200);
            send_pair(random_pair());
        end
        pair_ch.valid <= 1'b0;

        wait (pending_pieces.size() == 0);
        repeat (DRAIN_LEN) @(posedge clk);

        $display("Sent %0d prefix pairs; checked %0d pieces, %0d empty differences,",
                 pairs_sent, pieces_seen, empty_seen);
        $display("longest run %0d pieces, %0d mismatches.", longest_run, mismatches);
        if (mismatches == 0 && pending_pieces.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        stall_hold = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        stall_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        stall_hold <= 1'b0;
    end

    initial
    begin
        piece_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            piece_ch.ready <= !stall_hold && (steady || $urandom_range(0, 99) >= 7);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && piece_ch.valid && piece_ch.ready)
        begin
            pieces_seen++;
            run_len++;
            if (!piece_ch.present)
                empty_seen++;
            if (piece_ch.last)
            begin
                if (run_len > longest_run)
                    longest_run = run_len;
                run_len = 0;
            end
            if (pending_pieces.size() == 0)
            begin
                $error("unexpected piece transaction: addr=%h len=%0d present=%b last=%b",
                       piece_ch.piece_addr, piece_ch.piece_len, piece_ch.present,
                       piece_ch.last);
                mismatches++;
            end
            else
            begin
                want = pending_pieces.pop_front();
                if (piece_ch.piece_addr !== want.addr)
                begin
                    $error("piece_addr: expected %h, actual %h", want.addr,
                           piece_ch.piece_addr);
                    mismatches++;
                end
                if (piece_ch.piece_len !== want.len)
                begin
                    $error("piece_len: expected %0d, actual %0d", want.len,
                           piece_ch.piece_len);
                    mismatches++;
                end
                if (piece_ch.present !== want.present)
                begin
                    $error("present: expected %b, actual %b", want.present,
                           piece_ch.present);
                    mismatches++;
                end
                if (piece_ch.last !== want.last)
                begin
                    $error("last: expected %b, actual %b", want.last, piece_ch.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        pairs_sent  = 0;
        pieces_seen = 0;
        empty_seen  = 0;
        run_len     = 0;
        longest_run = 0;
        mismatches  = 0;
        #4_000_000;
        $display("Timed out with %0d pieces still expected.", pending_pieces.size());
        $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
sv/sps_pkg.sv
sv/sps_ifs.sv
sv/sps_front.sv
sv/sps_queue.sv
sv/sps_back.sv
sv/prefix_set_subtract.sv
sv/sps_checker.sv
dv/tb.sv
